/* sv/hidl_pkg.sv */
package hidl_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // field widths
  localparam int KEY_W   = 64;
  localparam int CNT_W   = 13;
  localparam int SLOT_W  = 12;
  localparam int OP_W    = 2;
  localparam int OUT_W   = 3;
  localparam int ENTRY_W = 2 * KEY_W;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

  // residue unit: bits of the key consumed per cycle
  localparam int MOD_STEP  = 4;
  localparam int MOD_ITERS = KEY_W / MOD_STEP;
  localparam int ITER_W    = $clog2(MOD_ITERS);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int                    APB_ADDR_W       = 3;
  localparam int                    APB_DATA_W       = 32;
  localparam logic [CNT_W-1:0]      BUCKET_COUNT_RST = 13'd4096;
  localparam logic                  REG_BUCKET_COUNT = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [OUT_W-1:0] {
    OC_INSERTED = 3'd0,
    OC_PRESENT  = 3'd1,
    OC_FULL     = 3'd2,
    OC_READ     = 3'd3,
    OC_CLEARED  = 3'd4,
    OC_IGNORED  = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MOD,
    FR_PUSH
  } fr_state_e;

  typedef enum logic [2:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_PROBE,
    BK_RD_WAIT
  } bk_state_e;

  // one classified item on its way to the back end
  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  end_point;
    logic [KEY_W-1:0]  start_point;
    logic [SLOT_W-1:0] bucket_index;
    logic [CNT_W-1:0]  n;
    logic [ADDR_W-1:0] home;
  } hidl_cmd_t;

  // queue side channel seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } hidl_qstat_t;

endpackage

/* sv/hidl_ram.sv */
module hidl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/hidl_front.sv */
module hidl_front import hidl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [KEY_W-1:0]  end_point_i,
  input  logic [KEY_W-1:0]  start_point_i,
  input  logic [SLOT_W-1:0] bucket_index_i,
  input  logic [CNT_W-1:0]  bucket_count_i,
  input  hidl_qstat_t       qstat_i,
  output logic              push_o,
  output hidl_cmd_t         cmd_o,
  output logic              idle_o
);

  fr_state_e         state_q, state_d;
  hidl_cmd_t         cmd_q, cmd_d;
  logic [KEY_W-1:0]  shift_q, shift_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [CNT_W-1:0]  n_sat;
  logic [CNT_W-1:0]  rem_next;

  // fold a few key bits into the running residue, one compare-subtract each
  function automatic logic [CNT_W-1:0] mod_digits(logic [CNT_W-1:0] rem,
                                                  logic [MOD_STEP-1:0] dig,
                                                  logic [CNT_W-1:0] n);
    logic [CNT_W:0] r;
    r = {1'b0, rem};
    for (int j = MOD_STEP - 1; j >= 0; j--) begin
      r = {r[CNT_W-1:0], dig[j]};
      if (r >= {1'b0, n}) begin
        r = r - {1'b0, n};
      end
    end
    return r[CNT_W-1:0];
  endfunction

  // probe modulus, saturated to the table depth
  assign n_sat = (32'(bucket_count_i) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : bucket_count_i;

  assign rem_next = mod_digits(rem_q, shift_q[KEY_W-1 -: MOD_STEP], cmd_q.n);

  // classify on accept, reduce the key of an insert, then hand over to the queue
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    iter_d  = iter_q;
    push_o  = 1'b0;
    unique case (state_q)
      FR_IDLE: begin
        if (accept_i) begin
          cmd_d.op           = op_e'(op_i);
          cmd_d.end_point    = end_point_i;
          cmd_d.start_point  = start_point_i;
          cmd_d.bucket_index = bucket_index_i;
          cmd_d.n            = n_sat;
          cmd_d.home         = '0;
          shift_d            = end_point_i;
          rem_d              = '0;
          iter_d             = '0;
          if (op_e'(op_i) == OP_INSERT && n_sat != '0) begin
            state_d = FR_MOD;
          end else begin
            state_d = FR_PUSH;
          end
        end
      end
      FR_MOD: begin
        rem_d   = rem_next;
        shift_d = shift_q << MOD_STEP;
        iter_d  = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(MOD_ITERS - 1)) begin
          cmd_d.home = ADDR_W'(rem_next);
          state_d    = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!qstat_i.full) begin
          push_o  = 1'b1;
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    shift_q <= shift_d;
    rem_q   <= rem_d;
    iter_q  <= iter_d;
  end

  assign cmd_o  = cmd_q;
  assign idle_o = (state_q == FR_IDLE);

endmodule

/* sv/hidl_queue.sv */
module hidl_queue import hidl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  hidl_cmd_t   push_cmd_i,
  input  logic        pop_i,
  output hidl_cmd_t   head_o,
  output hidl_qstat_t qstat_o
);

  hidl_cmd_t         entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  // pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_cmd_i;
    end
  end

  assign head_o        = entry_q[rd_q];
  assign qstat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);

endmodule

/* sv/hidl_back.sv */
module hidl_back import hidl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hidl_cmd_t         head_i,
  input  hidl_qstat_t       qstat_i,
  output logic              pop_o,
  output logic              init_sweep_o,
  output logic              done_o,
  output logic [OUT_W-1:0]  outcome_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic [KEY_W-1:0]  read_end_point_o,
  output logic [KEY_W-1:0]  read_start_point_o,
  output logic [CNT_W-1:0]  stored_count_o
);

  bk_state_e         state_q, state_d;
  hidl_cmd_t         cmd_q, cmd_d;
  logic [ADDR_W-1:0] b_q, b_d;
  logic [KEY_W-1:0]  cur_q, cur_d;
  logic [CNT_W-1:0]  probes_q, probes_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic              init_q, init_d;
  logic [CNT_W-1:0]  pair_q, pair_d;

  logic              done_q, done_d;
  outcome_e          outcome_q, outcome_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [KEY_W-1:0]  rep_q, rep_d;
  logic [KEY_W-1:0]  rsp_q, rsp_d;
  logic [CNT_W-1:0]  stored_q, stored_d;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [KEY_W-1:0]   rd_val;
  logic [CNT_W-1:0]   b_inc;
  logic [ADDR_W-1:0]  b_next;
  logic               idx_ok;

  // key and value of one bucket side by side
  hidl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_key = rdata[ENTRY_W-1 -: KEY_W];
  assign rd_val = rdata[KEY_W-1:0];

  // next probe bucket; the 64-bit probe value wrapping to zero restarts at bucket 0
  assign b_inc  = CNT_W'(b_q) + CNT_W'(1);
  assign b_next = (cur_q == EMPTY_KEY) ? '0 :
                  (b_inc == cmd_q.n)   ? '0 : ADDR_W'(b_inc);

  assign idx_ok = (32'(cmd_q.bucket_index) < 32'(TABLE_DEPTH));

  // sequencer: sweep, probe loop, bucket read, result
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    b_d       = b_q;
    cur_d     = cur_q;
    probes_d  = probes_q;
    sweep_d   = sweep_q;
    init_d    = init_q;
    pair_d    = pair_q;
    done_d    = 1'b0;
    outcome_d = outcome_q;
    slot_d    = slot_q;
    rep_d     = rep_q;
    rsp_d     = rsp_q;
    stored_d  = stored_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    waddr     = b_q;
    wdata     = {cmd_q.end_point, cmd_q.start_point};
    raddr     = b_next;
    unique case (state_q)
      BK_SWEEP: begin
        we      = 1'b1;
        waddr   = sweep_q;
        wdata   = {EMPTY_KEY, EMPTY_KEY};
        sweep_d = sweep_q + ADDR_W'(1);
        if (sweep_q == ADDR_W'(TABLE_DEPTH - 1)) begin
          pair_d  = '0;
          state_d = BK_IDLE;
          init_d  = 1'b0;
          if (!init_q) begin
            done_d    = 1'b1;
            outcome_d = OC_CLEARED;
            slot_d    = '0;
            rep_d     = '0;
            rsp_d     = '0;
            stored_d  = '0;
          end
        end
      end
      BK_IDLE: begin
        raddr = head_i.home;
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          unique case (head_i.op)
            OP_INSERT: begin
              if (head_i.n == '0) begin
                done_d    = 1'b1;
                outcome_d = OC_FULL;
                slot_d    = '0;
                rep_d     = '0;
                rsp_d     = '0;
                stored_d  = pair_q;
              end else begin
                b_d      = head_i.home;
                cur_d    = head_i.end_point;
                probes_d = '0;
                state_d  = BK_PROBE;
              end
            end
            OP_READ: begin
              raddr   = ADDR_W'(head_i.bucket_index);
              state_d = BK_RD_WAIT;
            end
            OP_CLEAR: begin
              sweep_d = '0;
              state_d = BK_SWEEP;
            end
            OP_NONE: begin
              done_d    = 1'b1;
              outcome_d = OC_IGNORED;
              slot_d    = '0;
              rep_d     = '0;
              rsp_d     = '0;
              stored_d  = pair_q;
            end
            default: state_d = BK_IDLE;
          endcase
        end
      end
      BK_PROBE: begin
        rep_d    = '0;
        rsp_d    = '0;
        stored_d = pair_q;
        priority if (rd_key == EMPTY_KEY) begin
          // empty bucket: store the pair here
          we        = 1'b1;
          pair_d    = pair_q + CNT_W'(1);
          stored_d  = pair_q + CNT_W'(1);
          done_d    = 1'b1;
          outcome_d = OC_INSERTED;
          slot_d    = SLOT_W'(b_q);
          state_d   = BK_IDLE;
        end else if (rd_key == cmd_q.end_point) begin
          done_d    = 1'b1;
          outcome_d = OC_PRESENT;
          slot_d    = SLOT_W'(b_q);
          state_d   = BK_IDLE;
        end else if (probes_q + CNT_W'(1) == cmd_q.n) begin
          done_d    = 1'b1;
          outcome_d = OC_FULL;
          slot_d    = '0;
          state_d   = BK_IDLE;
        end else begin
          // read of the next bucket is already under way
          b_d      = b_next;
          cur_d    = cur_q + KEY_W'(1);
          probes_d = probes_q + CNT_W'(1);
        end
      end
      BK_RD_WAIT: begin
        done_d    = 1'b1;
        outcome_d = OC_READ;
        slot_d    = cmd_q.bucket_index;
        rep_d     = idx_ok ? rd_key : EMPTY_KEY;
        rsp_d     = idx_ok ? rd_val : EMPTY_KEY;
        stored_d  = pair_q;
        state_d   = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_SWEEP;
      sweep_q <= '0;
      init_q  <= 1'b1;
      pair_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      init_q  <= init_d;
      pair_q  <= pair_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    b_q       <= b_d;
    cur_q     <= cur_d;
    probes_q  <= probes_d;
    outcome_q <= outcome_d;
    slot_q    <= slot_d;
    rep_q     <= rep_d;
    rsp_q     <= rsp_d;
    stored_q  <= stored_d;
  end

  assign init_sweep_o       = init_q;
  assign done_o             = done_q;
  assign outcome_o          = outcome_q;
  assign slot_o             = slot_q;
  assign read_end_point_o   = rep_q;
  assign read_start_point_o = rsp_q;
  assign stored_count_o     = stored_q;

endmodule

/* sv/hash_insert_dedup_linear_probe.sv */
// channel  | handshake                      | payload
// ---------+--------------------------------+------------------------------------------
// command  | start / busy (taken: start&!busy) | op_i, end_point_i, start_point_i, bucket_index_i
// result   | done_o, one cycle, no stall    | outcome_o, slot_o, read_end_point_o,
//          |                                | read_start_point_o, stored_count_o
// config   | apb write, pready tied high    | bucket_count at byte address 0
//
// front end: accept, then for an insert with a nonzero count the key residue (4 key bits
// per cycle), then the queue write (held while the queue is full); the back end pops the
// item, then probes bucket by bucket (insert), reads its bucket (read) or sweeps all 4096
// buckets (clear); after reset the same clearing pass runs with busy held high
// the front accepts the next item while the back end still probes (2-entry queue)
// results are never held: done_o marks each for exactly one cycle
module hash_insert_dedup_linear_probe import hidl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       op_i,
  input  logic [KEY_W-1:0]      end_point_i,
  input  logic [KEY_W-1:0]      start_point_i,
  input  logic [SLOT_W-1:0]     bucket_index_i,
  output logic                  done_o,
  output logic [OUT_W-1:0]      outcome_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic [KEY_W-1:0]      read_end_point_o,
  output logic [KEY_W-1:0]      read_start_point_o,
  output logic [CNT_W-1:0]      stored_count_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CNT_W-1:0] bucket_cnt_q;
  logic             cfg_wr;
  logic             accept;
  logic             front_idle;
  logic             init_sweep;
  logic             q_push;
  logic             q_pop;
  hidl_cmd_t        push_cmd;
  hidl_cmd_t        head_cmd;
  hidl_qstat_t      qstat;

  // register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_BUCKET_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_cnt_q <= BUCKET_COUNT_RST;
    end else if (cfg_wr) begin
      bucket_cnt_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[APB_ADDR_W-1] == REG_BUCKET_COUNT)
                  ? {{(APB_DATA_W - CNT_W){1'b0}}, bucket_cnt_q} : '0;

  // item handshake
  assign busy   = !front_idle || init_sweep;
  assign accept = start && !busy;

  hidl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .op_i           (op_i),
    .end_point_i    (end_point_i),
    .start_point_i  (start_point_i),
    .bucket_index_i (bucket_index_i),
    .bucket_count_i (bucket_cnt_q),
    .qstat_i        (qstat),
    .push_o         (q_push),
    .cmd_o          (push_cmd),
    .idle_o         (front_idle)
  );

  hidl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .qstat_o    (qstat)
  );

  hidl_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head_cmd),
    .qstat_i            (qstat),
    .pop_o              (q_pop),
    .init_sweep_o       (init_sweep),
    .done_o             (done_o),
    .outcome_o          (outcome_o),
    .slot_o             (slot_o),
    .read_end_point_o   (read_end_point_o),
    .read_start_point_o (read_start_point_o),
    .stored_count_o     (stored_count_o)
  );

`ifndef SYNTHESIS
  // the queue is never written while full nor read while empty
  a_queue_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && qstat.full) && !(q_pop && qstat.empty))
    else $error("command queue overflow or underflow");

  // no item is taken while the table is still being cleared after reset
  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_sweep |-> !accept && !done_o)
    else $error("item taken during reset clearing pass");

  // a clear always leaves an empty count
  a_clear_zeroes_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (outcome_o == OC_CLEARED) |-> (stored_count_o == '0))
    else $error("clear left a nonzero count");

  // only a bucket read carries bucket contents
  a_read_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (outcome_o != OC_READ) |->
      (read_end_point_o == '0) && (read_start_point_o == '0))
    else $error("bucket contents on a non-read result");
`endif

endmodule

/* tb/sv/hash_insert_dedup_linear_probe_tb.sv */
`timescale 1ns / 1ps

module hash_insert_dedup_linear_probe_tb;
  import hidl_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_COUNT  = 14;
  localparam int WRAP_INSERTS = 200;
  localparam int KEY_POOL_MAX = 32;

  // one result as seen on the result ports
  typedef struct packed {
    outcome_e          outcome;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  read_key;
    logic [KEY_W-1:0]  read_value;
    logic [CNT_W-1:0]  count;
  } table_result_t;

  // shadow copy of the bucket table plus the queue of results still owed
  class probe_table_tracker;
    logic [KEY_W-1:0] keys [TABLE_DEPTH];
    logic [KEY_W-1:0] vals [TABLE_DEPTH];
    logic [CNT_W-1:0] pairs;
    logic [CNT_W-1:0] bucket_count;
    table_result_t    due_results[$];
    int               mismatches;

    function void wipe();
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        keys[k] = EMPTY_KEY;
        vals[k] = EMPTY_KEY;
      end
      pairs = '0;
    endfunction

    function void set_bucket_count(logic [CNT_W-1:0] value);
      bucket_count = value;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // work out the result of one accepted item and apply it to the shadow table
    function void accept_command(op_e op, logic [KEY_W-1:0] ep, logic [KEY_W-1:0] sp,
                                 logic [SLOT_W-1:0] idx);
      table_result_t     r;
      logic [KEY_W-1:0]  n;
      logic [KEY_W-1:0]  probe;
      logic [KEY_W-1:0]  b;
      logic              hit;
      r.outcome    = OC_IGNORED;
      r.slot       = '0;
      r.read_key   = '0;
      r.read_value = '0;
      hit          = 1'b0;
      case (op)
        OP_INSERT: begin
          n = (bucket_count > TABLE_DEPTH) ? KEY_W'(TABLE_DEPTH) : KEY_W'(bucket_count);
          r.outcome = OC_FULL;
          for (longint unsigned i = 0; i < n && !hit; i++) begin
            probe = ep + KEY_W'(i);
            b = probe % n;
            if (keys[b[ADDR_W-1:0]] == EMPTY_KEY) begin
              keys[b[ADDR_W-1:0]] = ep;
              vals[b[ADDR_W-1:0]] = sp;
              pairs     = pairs + 1'b1;
              r.outcome = OC_INSERTED;
              r.slot    = b[SLOT_W-1:0];
              hit       = 1'b1;
            end else if (keys[b[ADDR_W-1:0]] == ep) begin
              r.outcome = OC_PRESENT;
              r.slot    = b[SLOT_W-1:0];
              hit       = 1'b1;
            end
          end
        end
        OP_READ: begin
          r.outcome    = OC_READ;
          r.slot       = idx;
          r.read_key   = keys[idx];
          r.read_value = vals[idx];
        end
        OP_CLEAR: begin
          wipe();
          r.outcome = OC_CLEARED;
        end
        default: begin
        end
      endcase
      r.count = pairs;
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [KEY_W-1:0] exp, logic [KEY_W-1:0] got);
      if (got !== exp) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, got);
        mismatches++;
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual outcome %0d slot %0d",
                 $time, got.outcome, got.slot);
        mismatches++;
        return;
      end
      exp = due_results.pop_front();
      compare_field("outcome", KEY_W'(exp.outcome), KEY_W'(got.outcome));
      compare_field("slot", KEY_W'(exp.slot), KEY_W'(got.slot));
      compare_field("read_end_point", exp.read_key, got.read_key);
      compare_field("read_start_point", exp.read_value, got.read_value);
      compare_field("stored_count", KEY_W'(exp.count), KEY_W'(got.count));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [OP_W-1:0]       op_i;
  logic [KEY_W-1:0]      end_point_i;
  logic [KEY_W-1:0]      start_point_i;
  logic [SLOT_W-1:0]     bucket_index_i;
  logic                  done_o;
  logic [OUT_W-1:0]      outcome_o;
  logic [SLOT_W-1:0]     slot_o;
  logic [KEY_W-1:0]      read_end_point_o;
  logic [KEY_W-1:0]      read_start_point_o;
  logic [CNT_W-1:0]      stored_count_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  probe_table_tracker tracker;
  table_result_t      observed;
  int                 burst_left;
  logic [KEY_W-1:0]   seen_keys[$];

  hash_insert_dedup_linear_probe dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .op_i               (op_i),
    .end_point_i        (end_point_i),
    .start_point_i      (start_point_i),
    .bucket_index_i     (bucket_index_i),
    .done_o             (done_o),
    .outcome_o          (outcome_o),
    .slot_o             (slot_o),
    .read_end_point_o   (read_end_point_o),
    .read_start_point_o (read_start_point_o),
    .stored_count_o     (stored_count_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #1 clk_i = ~clk_i;

  // result monitor: every strobed result is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      observed.outcome    = outcome_e'(outcome_o);
      observed.slot       = slot_o;
      observed.read_key   = read_end_point_o;
      observed.read_value = read_start_point_o;
      observed.count      = stored_count_o;
      tracker.check_result(observed);
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(input op_e op, input logic [KEY_W-1:0] ep,
                           input logic [KEY_W-1:0] sp, input logic [SLOT_W-1:0] idx);
    op_i           <= op;
    end_point_i    <= ep;
    start_point_i  <= sp;
    bucket_index_i <= idx;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    tracker.accept_command(op, ep, sp, idx);
  endtask

  // bursts of back-to-back items with random gaps in between
  task automatic paced_send(input op_e op, input logic [KEY_W-1:0] ep,
                            input logic [KEY_W-1:0] sp, input logic [SLOT_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send_item(op, ep, sp, idx);
  endtask

  // stop sending and let every owed result come out
  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write of the bucket count register, setup then access
  task automatic write_bucket_count(input logic [CNT_W-1:0] value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom;
    word[CNT_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BUCKET_COUNT, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_bucket_count(value);
  endtask

  function automatic logic [KEY_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SLOT_W-1:0] random_index();
    return SLOT_W'($urandom);
  endfunction

  // keys: repeats for dedup hits, small keys that collide, keys near the 2^64 wrap
  function automatic logic [KEY_W-1:0] pick_key(int n_eff);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35 && seen_keys.size() > 0)
      return seen_keys[$urandom_range(0, seen_keys.size() - 1)];
    if (roll < 60)
      return KEY_W'($urandom_range(0, 3 * n_eff + 8));
    if (roll < 75)
      return EMPTY_KEY - KEY_W'($urandom_range(1, 16));
    if (roll < 95)
      return random_word();
    return EMPTY_KEY;
  endfunction

  // hand-picked items: dedup, collisions, all-ones key, zero and saturated counts,
  // a probe sequence that wraps past 2^64 and ends full with a bucket left empty
  task automatic directed_items();
    write_bucket_count(BUCKET_COUNT_RST);
    paced_send(OP_READ,   random_word(), random_word(), '0);
    paced_send(OP_INSERT, '0, '0, random_index());
    paced_send(OP_INSERT, '0, EMPTY_KEY, random_index());
    paced_send(OP_INSERT, 64'd4096, 64'd1, random_index());
    paced_send(OP_INSERT, EMPTY_KEY, 64'h0123_4567_89ab_cdef, random_index());
    paced_send(OP_INSERT, EMPTY_KEY, 64'd2, random_index());
    paced_send(OP_INSERT, EMPTY_KEY - 64'd1, EMPTY_KEY, random_index());
    paced_send(OP_READ,   random_word(), random_word(), 12'd4095);
    paced_send(OP_READ,   random_word(), random_word(), 12'd1);
    paced_send(OP_READ,   random_word(), random_word(), 12'd4094);
    paced_send(OP_NONE,   random_word(), random_word(), random_index());
    settle();
    // zero buckets: nothing probed
    write_bucket_count('0);
    paced_send(OP_INSERT, 64'd5, random_word(), random_index());
    paced_send(OP_READ,   random_word(), random_word(), '0);
    settle();
    // count above depth saturates
    write_bucket_count('1);
    paced_send(OP_INSERT, 64'd4097, random_word(), random_index());
    paced_send(OP_INSERT, EMPTY_KEY - 64'd1, random_word(), random_index());
    settle();
    // three buckets, key near the wrap probes 2, 0, 0
    write_bucket_count(13'd3);
    paced_send(OP_CLEAR,  random_word(), random_word(), random_index());
    paced_send(OP_INSERT, '0, random_word(), random_index());
    paced_send(OP_INSERT, 64'd2, random_word(), random_index());
    paced_send(OP_INSERT, EMPTY_KEY - 64'd1, random_word(), random_index());
    paced_send(OP_READ,   random_word(), random_word(), 12'd1);
    paced_send(OP_CLEAR,  random_word(), random_word(), random_index());
    settle();
  endtask

  // all-ones key into one bucket over and over; the bucket still looks empty,
  // so every insert lands there and is counted
  task automatic count_wrap_items();
    write_bucket_count(13'd1);
    paced_send(OP_CLEAR, random_word(), random_word(), random_index());
    for (int k = 0; k < WRAP_INSERTS; k++) begin
      paced_send(OP_INSERT, EMPTY_KEY, random_word(), random_index());
      if (k % 32 == 0)
        paced_send(OP_READ, random_word(), random_word(), '0);
    end
    settle();
  endtask

  // random mix under a series of bucket counts
  task automatic random_phases();
    logic [CNT_W-1:0] plan [PHASE_COUNT];
    int               n_eff;
    int               issued;
    int               roll;
    op_e              op;
    logic [KEY_W-1:0] ep;
    logic [SLOT_W-1:0] idx;
    plan = '{13'd4096, 13'd1, 13'd2, 13'd0, 13'd3, 13'd8191, 13'd5, 13'd4095,
             13'd13, 13'd5000, 13'd64, 13'd0, 13'd7, 13'd4096};
    plan[11] = CNT_W'($urandom_range(6, 300));
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_bucket_count(plan[p]);
      n_eff = (plan[p] > TABLE_DEPTH) ? TABLE_DEPTH : int'(plan[p]);
      issued = 0;
      while (issued < RANDOM_ITEMS / PHASE_COUNT) begin
        roll = $urandom_range(0, 99);
        if (roll < 64)      op = OP_INSERT;
        else if (roll < 90) op = OP_READ;
        else if (roll < 92) op = OP_CLEAR;
        else                op = OP_NONE;
        ep = pick_key(n_eff);
        if (n_eff > 0 && $urandom_range(0, 9) < 6)
          idx = SLOT_W'($urandom_range(0, n_eff - 1));
        else
          idx = random_index();
        paced_send(op, ep, random_word(), idx);
        if (op == OP_INSERT) begin
          seen_keys.push_back(ep);
          if (seen_keys.size() > KEY_POOL_MAX)
            void'(seen_keys.pop_front());
        end
        if (op != OP_NONE)
          issued++;
      end
      settle();
    end
  endtask

  // main sequence
  initial begin
    tracker = new;
    tracker.wipe();
    tracker.set_bucket_count(BUCKET_COUNT_RST);
    burst_left     = 0;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    op_i           <= OP_NONE;
    end_point_i    <= '0;
    start_point_i  <= '0;
    bucket_index_i <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // clearing pass after reset
    while (busy !== 1'b0) @(posedge clk_i);
    directed_items();
    count_wrap_items();
    random_phases();
    settle();
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #300_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
